// ===== src/scbpa_pkg.sv =====
`default_nettype none

package scbpa_pkg;

   // Block sizes in bytes and the matching address shifts.
   localparam logic [31:0] BYTES_LARGE = 32'h0010_0000;
   localparam logic [31:0] BYTES_MID   = 32'h0008_0000;
   localparam logic [31:0] BYTES_SMALL = 32'h0001_0000;
   localparam logic [31:0] BYTES_TINY  = 32'h0000_4000;

   localparam int SHIFT_LARGE = 20;
   localparam int SHIFT_MID   = 19;
   localparam int SHIFT_SMALL = 16;
   localparam int SHIFT_TINY  = 14;

   localparam logic KIND_ALLOC   = 1'b0;
   localparam logic KIND_RELEASE = 1'b1;

   localparam logic [1:0] CLASS_LARGE = 2'd0;
   localparam logic [1:0] CLASS_MID   = 2'd1;
   localparam logic [1:0] CLASS_SMALL = 2'd2;
   localparam logic [1:0] CLASS_TINY  = 2'd3;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_ZERO      = 3'd1,
      ST_TOO_LARGE = 3'd2,
      ST_FULL      = 3'd3,
      ST_NO_MATCH  = 3'd4,
      ST_NOT_ALLOC = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_SCAN,
      S_MATCH,
      S_CHECK,
      S_COMMIT,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic load_req;
      logic decode;
      logic scan;
      logic match;
      logic check;
      logic commit;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic early_err;
      logic is_release;
      logic word_free;
      logic word_last;
      logic match_ok;
   } flags_type;

endpackage

`default_nettype wire

// ===== src/scbpa_ctrl.sv =====
`default_nettype none

module scbpa_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   input  wire scbpa_pkg::flags_type flags,
   output scbpa_pkg::cmd_type       cmd
);

   scbpa_pkg::state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= scbpa_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      case (state_ff)
         scbpa_pkg::S_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = scbpa_pkg::S_DECODE;
            end
         end
         scbpa_pkg::S_DECODE: begin
            cmd.decode = 1'b1;
            if (flags.early_err) begin
               state_in = scbpa_pkg::S_FINISH;
            end else if (flags.is_release) begin
               state_in = scbpa_pkg::S_MATCH;
            end else begin
               state_in = scbpa_pkg::S_SCAN;
            end
         end
         scbpa_pkg::S_SCAN: begin
            cmd.scan = 1'b1;
            if (flags.word_free) begin
               state_in = scbpa_pkg::S_COMMIT;
            end else if (flags.word_last) begin
               state_in = scbpa_pkg::S_FINISH;
            end
         end
         scbpa_pkg::S_MATCH: begin
            cmd.match = 1'b1;
            state_in  = flags.match_ok ? scbpa_pkg::S_CHECK : scbpa_pkg::S_FINISH;
         end
         scbpa_pkg::S_CHECK: begin
            cmd.check = 1'b1;
            state_in  = scbpa_pkg::S_FINISH;
         end
         scbpa_pkg::S_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = scbpa_pkg::S_FINISH;
         end
         scbpa_pkg::S_FINISH: begin
            // hold until the output register is free or being drained
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.finish   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = scbpa_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = scbpa_pkg::S_IDLE;
         end
      endcase
   end

   assign req_stall = (state_ff != scbpa_pkg::S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// ===== src/scbpa_datapath.sv =====
`default_nettype none

module scbpa_datapath #(
   parameter int LARGE_BLOCKS = 4,
   parameter int MID_BLOCKS   = 8,
   parameter int SMALL_BLOCKS = 64,
   parameter int TINY_BLOCKS  = 256
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire scbpa_pkg::cmd_type  cmd,
   output scbpa_pkg::flags_type     flags,
   input  wire logic                csr_write_enable,
   input  wire logic [63:0]         csr_write_data,
   input  wire logic                req_kind,
   input  wire logic [31:0]         req_size_bytes,
   input  wire logic [63:0]         req_release_address,
   output logic [2:0]               rsp_status,
   output logic [63:0]              rsp_block_address,
   output logic [1:0]               rsp_size_class,
   output logic [8:0]               rsp_free_left
);

   localparam int WORDS_L = (LARGE_BLOCKS + 63) / 64;
   localparam int WORDS_M = (MID_BLOCKS + 63) / 64;
   localparam int WORDS_S = (SMALL_BLOCKS + 63) / 64;
   localparam int WORDS_T = (TINY_BLOCKS + 63) / 64;
   localparam int MAXW_LM = (WORDS_L > WORDS_M) ? WORDS_L : WORDS_M;
   localparam int MAXW_ST = (WORDS_S > WORDS_T) ? WORDS_S : WORDS_T;
   localparam int MAXW    = (MAXW_LM > MAXW_ST) ? MAXW_LM : MAXW_ST;
   localparam int WORD_W  = (MAXW > 1) ? $clog2(MAXW) : 1;
   localparam int IDX_W   = WORD_W + 6;
   localparam int PAD_W   = MAXW * 64;

   localparam int CNT_L_W = $clog2(LARGE_BLOCKS + 1);
   localparam int CNT_M_W = $clog2(MID_BLOCKS + 1);
   localparam int CNT_S_W = $clog2(SMALL_BLOCKS + 1);
   localparam int CNT_T_W = $clog2(TINY_BLOCKS + 1);

   localparam logic [WORD_W-1:0] LAST_L = WORD_W'(WORDS_L - 1);
   localparam logic [WORD_W-1:0] LAST_M = WORD_W'(WORDS_M - 1);
   localparam logic [WORD_W-1:0] LAST_S = WORD_W'(WORDS_S - 1);
   localparam logic [WORD_W-1:0] LAST_T = WORD_W'(WORDS_T - 1);

   localparam logic [63:0] OFF_MID   = 64'(LARGE_BLOCKS) << scbpa_pkg::SHIFT_LARGE;
   localparam logic [63:0] OFF_SMALL = OFF_MID + (64'(MID_BLOCKS) << scbpa_pkg::SHIFT_MID);
   localparam logic [63:0] OFF_TINY  = OFF_SMALL + (64'(SMALL_BLOCKS) << scbpa_pkg::SHIFT_SMALL);

   // lowest clear bit of a word, by halving the window six times
   function automatic logic [5:0] first_zero(input logic [63:0] w);
      logic [63:0] v;
      logic [63:0] m;
      logic [5:0]  p;
      v = ~w;
      p = '0;
      for (int s = 5; s >= 0; s--) begin
         m = (64'd1 << (1 << s)) - 64'd1;
         if ((v & m) == '0) begin
            p[s] = 1'b1;
            v    = v >> (1 << s);
         end
      end
      return p;
   endfunction

   logic [63:0]               base_ff;
   logic                      kind_ff;
   logic [63:0]               addr_ff;
   logic [1:0]                cls_ff, cls_in;
   scbpa_pkg::status_type     stat_ff, stat_in;
   logic [63:0]               start_ff;
   logic [63:0]               blk_ff;
   logic [WORD_W-1:0]         word_ff;
   logic [IDX_W-1:0]          idx_ff;

   logic [LARGE_BLOCKS-1:0]   large_ff, large_in;
   logic [MID_BLOCKS-1:0]     mid_ff, mid_in;
   logic [SMALL_BLOCKS-1:0]   small_ff, small_in;
   logic [TINY_BLOCKS-1:0]    tiny_ff, tiny_in;
   logic [CNT_L_W-1:0]        cnt_l_ff, cnt_l_in;
   logic [CNT_M_W-1:0]        cnt_m_ff, cnt_m_in;
   logic [CNT_S_W-1:0]        cnt_s_ff, cnt_s_in;
   logic [CNT_T_W-1:0]        cnt_t_ff, cnt_t_in;

   logic [2:0]                rsp_status_ff;
   logic [63:0]               rsp_block_address_ff;
   logic [1:0]                rsp_size_class_ff;
   logic [8:0]                rsp_free_left_ff;

   logic [PAD_W-1:0]          pad_l, pad_m, pad_s, pad_t;
   logic [63:0]               cword;
   logic [WORD_W-1:0]         last_sel;
   logic [63:0]               off_sel;
   logic [63:0]               nblk_sel;
   logic [31:0]               cnt_sel;
   logic [63:0]               rel_off;
   logic [63:0]               rel_quot;
   logic [63:0]               rel_rem;
   logic                      bit_now;
   logic                      word_free;
   logic [5:0]                zero_pos;
   int                        shift_sel;

   // unused bits past the class size read as allocated
   always_comb begin
      pad_l = '1;
      pad_m = '1;
      pad_s = '1;
      pad_t = '1;
      pad_l[LARGE_BLOCKS-1:0] = large_ff;
      pad_m[MID_BLOCKS-1:0]   = mid_ff;
      pad_s[SMALL_BLOCKS-1:0] = small_ff;
      pad_t[TINY_BLOCKS-1:0]  = tiny_ff;
   end

   always_comb begin
      case (cls_ff)
         scbpa_pkg::CLASS_LARGE: begin
            cword     = pad_l[{word_ff, 6'd0} +: 64];
            last_sel  = LAST_L;
            off_sel   = '0;
            nblk_sel  = 64'(LARGE_BLOCKS);
            cnt_sel   = 32'(cnt_l_ff);
            shift_sel = scbpa_pkg::SHIFT_LARGE;
         end
         scbpa_pkg::CLASS_MID: begin
            cword     = pad_m[{word_ff, 6'd0} +: 64];
            last_sel  = LAST_M;
            off_sel   = OFF_MID;
            nblk_sel  = 64'(MID_BLOCKS);
            cnt_sel   = 32'(cnt_m_ff);
            shift_sel = scbpa_pkg::SHIFT_MID;
         end
         scbpa_pkg::CLASS_SMALL: begin
            cword     = pad_s[{word_ff, 6'd0} +: 64];
            last_sel  = LAST_S;
            off_sel   = OFF_SMALL;
            nblk_sel  = 64'(SMALL_BLOCKS);
            cnt_sel   = 32'(cnt_s_ff);
            shift_sel = scbpa_pkg::SHIFT_SMALL;
         end
         default: begin
            cword     = pad_t[{word_ff, 6'd0} +: 64];
            last_sel  = LAST_T;
            off_sel   = OFF_TINY;
            nblk_sel  = 64'(TINY_BLOCKS);
            cnt_sel   = 32'(cnt_t_ff);
            shift_sel = scbpa_pkg::SHIFT_TINY;
         end
      endcase
   end

   assign word_free = ~&cword;
   assign zero_pos  = first_zero(cword);
   assign bit_now   = cword[idx_ff[5:0]];
   assign rel_off   = addr_ff - start_ff;
   assign rel_quot  = rel_off >> shift_sel;
   assign rel_rem   = rel_off & ((64'd1 << shift_sel) - 64'd1);

   always_comb begin
      flags.early_err  = (stat_ff != scbpa_pkg::ST_OK);
      flags.is_release = (kind_ff == scbpa_pkg::KIND_RELEASE);
      flags.word_free  = word_free;
      flags.word_last  = (word_ff == last_sel);
      flags.match_ok   = (rel_rem == '0) && (rel_quot < nblk_sel);
   end

   // classify the request on accept
   always_comb begin
      cls_in  = scbpa_pkg::CLASS_TINY;
      stat_in = scbpa_pkg::ST_OK;
      if (req_size_bytes > scbpa_pkg::BYTES_MID) begin
         cls_in = scbpa_pkg::CLASS_LARGE;
      end else if (req_size_bytes > scbpa_pkg::BYTES_SMALL) begin
         cls_in = scbpa_pkg::CLASS_MID;
      end else if (req_size_bytes > scbpa_pkg::BYTES_TINY) begin
         cls_in = scbpa_pkg::CLASS_SMALL;
      end
      if (req_size_bytes == '0) begin
         stat_in = scbpa_pkg::ST_ZERO;
         cls_in  = scbpa_pkg::CLASS_LARGE;
      end else if (req_kind == scbpa_pkg::KIND_ALLOC &&
                   req_size_bytes > scbpa_pkg::BYTES_LARGE) begin
         stat_in = scbpa_pkg::ST_TOO_LARGE;
         cls_in  = scbpa_pkg::CLASS_LARGE;
      end
   end

   // bitmap and free-count updates
   always_comb begin
      large_in = large_ff;
      mid_in   = mid_ff;
      small_in = small_ff;
      tiny_in  = tiny_ff;
      cnt_l_in = cnt_l_ff;
      cnt_m_in = cnt_m_ff;
      cnt_s_in = cnt_s_ff;
      cnt_t_in = cnt_t_ff;
      if (cmd.commit || (cmd.check && bit_now)) begin
         case (cls_ff)
            scbpa_pkg::CLASS_LARGE: begin
               for (int i = 0; i < LARGE_BLOCKS; i++) begin
                  if (idx_ff == IDX_W'(i)) large_in[i] = cmd.commit;
               end
               if (cmd.commit && cnt_l_ff != '0) cnt_l_in = cnt_l_ff - 1'b1;
               if (cmd.check && cnt_l_ff != CNT_L_W'(LARGE_BLOCKS))
                  cnt_l_in = cnt_l_ff + 1'b1;
            end
            scbpa_pkg::CLASS_MID: begin
               for (int i = 0; i < MID_BLOCKS; i++) begin
                  if (idx_ff == IDX_W'(i)) mid_in[i] = cmd.commit;
               end
               if (cmd.commit && cnt_m_ff != '0) cnt_m_in = cnt_m_ff - 1'b1;
               if (cmd.check && cnt_m_ff != CNT_M_W'(MID_BLOCKS))
                  cnt_m_in = cnt_m_ff + 1'b1;
            end
            scbpa_pkg::CLASS_SMALL: begin
               for (int i = 0; i < SMALL_BLOCKS; i++) begin
                  if (idx_ff == IDX_W'(i)) small_in[i] = cmd.commit;
               end
               if (cmd.commit && cnt_s_ff != '0) cnt_s_in = cnt_s_ff - 1'b1;
               if (cmd.check && cnt_s_ff != CNT_S_W'(SMALL_BLOCKS))
                  cnt_s_in = cnt_s_ff + 1'b1;
            end
            default: begin
               for (int i = 0; i < TINY_BLOCKS; i++) begin
                  if (idx_ff == IDX_W'(i)) tiny_in[i] = cmd.commit;
               end
               if (cmd.commit && cnt_t_ff != '0) cnt_t_in = cnt_t_ff - 1'b1;
               if (cmd.check && cnt_t_ff != CNT_T_W'(TINY_BLOCKS))
                  cnt_t_in = cnt_t_ff + 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= '0;
         large_ff <= '0;
         mid_ff   <= '0;
         small_ff <= '0;
         tiny_ff  <= '0;
         cnt_l_ff <= CNT_L_W'(LARGE_BLOCKS);
         cnt_m_ff <= CNT_M_W'(MID_BLOCKS);
         cnt_s_ff <= CNT_S_W'(SMALL_BLOCKS);
         cnt_t_ff <= CNT_T_W'(TINY_BLOCKS);
      end else begin
         if (csr_write_enable) base_ff <= csr_write_data;
         large_ff <= large_in;
         mid_ff   <= mid_in;
         small_ff <= small_in;
         tiny_ff  <= tiny_in;
         cnt_l_ff <= cnt_l_in;
         cnt_m_ff <= cnt_m_in;
         cnt_s_ff <= cnt_s_in;
         cnt_t_ff <= cnt_t_in;
      end
   end

   // per-request working registers
   always_ff @(posedge clock) begin
      if (reset) begin
         stat_ff <= scbpa_pkg::ST_OK;
      end else begin
         if (cmd.load_req) begin
            stat_ff <= stat_in;
         end else if (cmd.scan && !word_free && flags.word_last) begin
            stat_ff <= scbpa_pkg::ST_FULL;
         end else if (cmd.match && !flags.match_ok) begin
            stat_ff <= scbpa_pkg::ST_NO_MATCH;
         end else if (cmd.check && !bit_now) begin
            stat_ff <= scbpa_pkg::ST_NOT_ALLOC;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         kind_ff <= req_kind;
         addr_ff <= req_release_address;
         cls_ff  <= cls_in;
         word_ff <= '0;
      end
      if (cmd.decode) begin
         start_ff <= base_ff + off_sel;
      end
      if (cmd.scan) begin
         if (word_free) begin
            idx_ff <= {word_ff, zero_pos};
         end else begin
            word_ff <= word_ff + 1'b1;
         end
      end
      if (cmd.match) begin
         idx_ff  <= rel_quot[IDX_W-1:0];
         word_ff <= rel_quot[IDX_W-1:6];
      end
      if (cmd.commit) begin
         blk_ff <= start_ff + (64'(idx_ff) << shift_sel);
      end
      if (cmd.check) begin
         blk_ff <= addr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_status_ff        <= stat_ff;
         rsp_block_address_ff <= (stat_ff == scbpa_pkg::ST_OK) ? blk_ff : '0;
         rsp_size_class_ff    <= cls_ff;
         if (stat_ff == scbpa_pkg::ST_ZERO || stat_ff == scbpa_pkg::ST_TOO_LARGE) begin
            rsp_free_left_ff <= '0;
         end else begin
            rsp_free_left_ff <= cnt_sel[8:0];
         end
      end
   end

   assign rsp_status        = rsp_status_ff;
   assign rsp_block_address = rsp_block_address_ff;
   assign rsp_size_class    = rsp_size_class_ff;
   assign rsp_free_left     = rsp_free_left_ff;

endmodule

`default_nettype wire

// ===== src/size_class_block_pool_allocator_top.sv =====
`default_nettype none

// Block pool allocator with four size classes laid out back to back from
// the base address in the csr register: 1 MiB, 512 KiB, 64 KiB and 16 KiB
// blocks. An allocate takes the lowest free block of the smallest class
// that fits; a release frees the block whose start matches the address.
// Each request gives one response word. Size errors go straight to the
// response; a release matches the address against the block starts of the
// class and then checks the bitmap; an allocate scans the 64-bit bitmap
// words of the class with the first-free search (one word per cycle, 1 to
// 4 words at the default class sizes) and commits the first free block.
// The response sits in an output register, so a new request is taken while
// an earlier response is still stalled; that request then holds in its
// final state until the earlier word drains. The bitmaps are cleared by
// reset, and the base register may be rewritten only while no request is
// in flight.
module size_class_block_pool_allocator_top #(
   parameter int LARGE_BLOCKS = 4,
   parameter int MID_BLOCKS   = 8,
   parameter int SMALL_BLOCKS = 64,
   parameter int TINY_BLOCKS  = 256
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_kind,
   input  wire logic [31:0] req_size_bytes,
   input  wire logic [63:0] req_release_address,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [2:0]       rsp_status,
   output logic [63:0]      rsp_block_address,
   output logic [1:0]       rsp_size_class,
   output logic [8:0]       rsp_free_left,
   input  wire logic        csr_write_enable,
   input  wire logic [63:0] csr_write_data
);

   scbpa_pkg::cmd_type   cmd;
   scbpa_pkg::flags_type flags;

   scbpa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .flags     (flags),
      .cmd       (cmd)
   );

   scbpa_datapath #(
      .LARGE_BLOCKS (LARGE_BLOCKS),
      .MID_BLOCKS   (MID_BLOCKS),
      .SMALL_BLOCKS (SMALL_BLOCKS),
      .TINY_BLOCKS  (TINY_BLOCKS)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .flags               (flags),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data),
      .req_kind            (req_kind),
      .req_size_bytes      (req_size_bytes),
      .req_release_address (req_release_address),
      .rsp_status          (rsp_status),
      .rsp_block_address   (rsp_block_address),
      .rsp_size_class      (rsp_size_class),
      .rsp_free_left       (rsp_free_left)
   );

endmodule

`default_nettype wire

// ===== src/scbpa_checker.sv =====
`default_nettype none

module scbpa_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [2:0]  rsp_status,
   input wire logic [63:0] rsp_block_address,
   input wire logic [1:0]  rsp_size_class,
   input wire logic [8:0]  rsp_free_left
);

   // a stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status) &&
         $stable(rsp_block_address) && $stable(rsp_free_left))
      else $error("response word changed while stalled");

   a_err_addr_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != scbpa_pkg::ST_OK |-> rsp_block_address == '0)
      else $error("failed request returned a block address");

   a_size_err_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == scbpa_pkg::ST_ZERO ||
                    rsp_status == scbpa_pkg::ST_TOO_LARGE)
      |-> rsp_size_class == scbpa_pkg::CLASS_LARGE && rsp_free_left == '0)
      else $error("size error with nonzero class or free count");

   a_full_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == scbpa_pkg::ST_FULL |-> rsp_free_left == '0)
      else $error("class reported full with free blocks left");

endmodule

bind size_class_block_pool_allocator_top scbpa_checker u_scbpa_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_status        (rsp_status),
   .rsp_block_address (rsp_block_address),
   .rsp_size_class    (rsp_size_class),
   .rsp_free_left     (rsp_free_left)
);

`default_nettype wire
